[rtl/hpq_pkg.sv]
// Shared types and constants of the binary heap priority queue.
// Holds the field widths, status codes, microcode word layout and step codes.
// No dependencies.
package hpq_pkg;

    localparam int HPQ_CAPACITY = 64;
    localparam int VAL_W        = 32;
    localparam int PRI_W        = 32;
    localparam int ENTRY_W      = VAL_W + PRI_W;
    localparam int S_DW         = 64;
    localparam int STAT_W       = 2;

    localparam logic signed [VAL_W-1:0] VALUE_NONE = -32'sd1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        MODE_INSERT  = 1'b0,
        MODE_EXTRACT = 1'b1
    } t_mode;

    // Program steps; the response step sits at address zero so that it falls into wait.
    typedef enum logic [3:0] {
        ST_RESP,
        ST_WAIT,
        ST_SORT,
        ST_KIND,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_EXT_RD,
        ST_EXT_LOAD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DN_PUT
    } t_step;

    typedef enum logic [1:0] {
        RD_PARENT,
        RD_ROOT_LAST,
        RD_CHILDREN
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_PARENT,
        WR_BEST,
        WR_CUR
    } t_wr_sel;

    typedef enum logic [1:0] {
        POS_HOLD,
        POS_ROOT,
        POS_PARENT,
        POS_BEST
    } t_pos_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_REQ,
        C_REJECT,
        C_EXTRACT,
        C_POS_ZERO,
        C_CUR_GT_PAR,
        C_CHILD_WIN,
        C_OUT_BUSY
    } t_cond;

    // Datapath controls of one step
    typedef struct packed {
        logic     in_ready;
        t_rd_sel  rd_sel;
        t_wr_sel  wr_sel;
        t_pos_sel pos_sel;
        t_cnt_op  cnt_op;
        logic     load_ext;
        logic     out_load;
    } t_uctrl;

    // Full control word as held in the program table
    typedef struct packed {
        t_uctrl ctl;
        t_cond  cond;
        logic   ex_on_take;
        t_step  target;
    } t_uword;

    // Branch conditions reported by the datapath
    typedef struct packed {
        logic no_req;
        logic reject;
        logic extract;
        logic pos_zero;
        logic cur_gt_par;
        logic child_win;
        logic out_busy;
    } t_flags;

endpackage

[rtl/hpq_ram.sv]
// Generic simple RAM: one write port and two read ports with registered read data.
// No dependencies.
module hpq_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[rtl/hpq_seq.sv]
// Microcode sequencer of the heap queue: program table, step counter and branch unit.
// Depends on hpq_pkg for the control word, step codes and condition flags.
module hpq_seq import hpq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_uctrl o_ctrl
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_take;

    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        w.ctl = '{in_ready: 1'b0, rd_sel: RD_PARENT, wr_sel: WR_NONE, pos_sel: POS_HOLD,
                  cnt_op: CNT_HOLD, load_ext: 1'b0, out_load: 1'b0};
        w.cond       = C_NEXT;
        w.ex_on_take = 1'b0;
        w.target     = ST_WAIT;
        unique case (step)
            ST_RESP: begin
                w.ctl.out_load = 1'b1;
                w.cond         = C_OUT_BUSY;
                w.target       = ST_RESP;
            end
            ST_WAIT: begin
                w.ctl.in_ready = 1'b1;
                w.cond         = C_NO_REQ;
                w.target       = ST_WAIT;
            end
            ST_SORT: begin
                w.cond   = C_REJECT;
                w.target = ST_RESP;
            end
            ST_KIND: begin
                w.cond   = C_EXTRACT;
                w.target = ST_EXT_RD;
            end
            ST_INS_RD: begin
                w.ctl.rd_sel = RD_PARENT;
                w.cond       = C_POS_ZERO;
                w.target     = ST_INS_PUT;
            end
            ST_INS_CMP: begin
                // move the parent down into the hole and climb, only when the new entry wins
                w.ctl.wr_sel  = WR_PARENT;
                w.ctl.pos_sel = POS_PARENT;
                w.cond        = C_CUR_GT_PAR;
                w.ex_on_take  = 1'b1;
                w.target      = ST_INS_RD;
            end
            ST_INS_PUT: begin
                w.ctl.wr_sel = WR_CUR;
                w.ctl.cnt_op = CNT_INC;
                w.cond       = C_ALWAYS;
                w.target     = ST_RESP;
            end
            ST_EXT_RD: begin
                w.ctl.rd_sel  = RD_ROOT_LAST;
                w.ctl.cnt_op  = CNT_DEC;
                w.ctl.pos_sel = POS_ROOT;
            end
            ST_EXT_LOAD: begin
                w.ctl.load_ext = 1'b1;
            end
            ST_DN_RD: begin
                w.ctl.rd_sel = RD_CHILDREN;
            end
            ST_DN_CMP: begin
                w.ctl.wr_sel  = WR_BEST;
                w.ctl.pos_sel = POS_BEST;
                w.cond        = C_CHILD_WIN;
                w.ex_on_take  = 1'b1;
                w.target      = ST_DN_RD;
            end
            ST_DN_PUT: begin
                w.ctl.wr_sel = WR_CUR;
                w.cond       = C_ALWAYS;
                w.target     = ST_RESP;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = ST_WAIT;
            end
        endcase
        return w;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_word = uc_rom(r_step);
        unique case (w_word.cond)
            C_NEXT:       w_take = 1'b0;
            C_ALWAYS:     w_take = 1'b1;
            C_NO_REQ:     w_take = i_flags.no_req;
            C_REJECT:     w_take = i_flags.reject;
            C_EXTRACT:    w_take = i_flags.extract;
            C_POS_ZERO:   w_take = i_flags.pos_zero;
            C_CUR_GT_PAR: w_take = i_flags.cur_gt_par;
            C_CHILD_WIN:  w_take = i_flags.child_win;
            C_OUT_BUSY:   w_take = i_flags.out_busy;
            default:      w_take = 1'b0;
        endcase
        n_step = w_take ? w_word.target : t_step'(r_step + 1'b1);
        o_ctrl = w_word.ctl;
        // drop the step's moves when its branch falls through
        if (w_word.ex_on_take && !w_take) begin
            o_ctrl.wr_sel  = WR_NONE;
            o_ctrl.pos_sel = POS_HOLD;
        end
    end

endmodule

[rtl/binary_heap_priority_queue_core.sv]
// Channel   Dir  tdata (low bit up)                         tuser
// s_axis    in   item_value[31:0], item_priority[63:32]     mode
// m_axis    out  out_value[31:0], occupancy, zero padding   status
//
// Top level of the heap priority queue; depends on hpq_pkg, hpq_ram and hpq_seq.
// One request is worked on at a time; the heap sits in a RAM with registered reads,
// so every sift level takes a read step, then a compare-and-write step.
// The result register lets the next request in while a result still waits.
// Reset (synchronous, active low) empties the queue; the RAM contents are not cleared.
module binary_heap_priority_queue_core import hpq_pkg::*; #(
    parameter  int CAPACITY = HPQ_CAPACITY,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int M_DW     = ((VAL_W + CNT_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [S_DW-1:0]   i_s_axis_tdata,   // item_value, item_priority
    input  logic              i_s_axis_tuser,   // mode
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [M_DW-1:0]   o_m_axis_tdata,   // out_value, occupancy, zero padding
    output logic [STAT_W-1:0] o_m_axis_tuser    // status
);

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int LW     = ADDR_W + 2;

    t_uctrl w_ctrl;
    t_flags w_flags;
    logic   w_s_acc;

    t_mode                    r_mode;
    t_status                  r_status;
    logic [CNT_W-1:0]         r_count;
    logic [ADDR_W-1:0]        r_pos;
    logic signed [VAL_W-1:0]  r_cur_v;
    logic signed [PRI_W-1:0]  r_cur_p;
    logic signed [VAL_W-1:0]  r_res_v;

    logic                     r_o_valid;
    logic signed [VAL_W-1:0]  r_o_value;
    t_status                  r_o_status;
    logic [CNT_W-1:0]         r_o_count;

    logic                     w_we;
    logic [ENTRY_W-1:0]       w_wdata;
    logic [ADDR_W-1:0]        w_raddr_a;
    logic [ADDR_W-1:0]        w_raddr_b;
    logic [ENTRY_W-1:0]       w_rdata_a;
    logic [ENTRY_W-1:0]       w_rdata_b;

    logic signed [VAL_W-1:0]  w_a_v;
    logic signed [PRI_W-1:0]  w_a_p;
    logic signed [VAL_W-1:0]  w_b_v;
    logic signed [PRI_W-1:0]  w_b_p;

    logic [ADDR_W-1:0]        w_parent;
    logic [CNT_W-1:0]         w_last;
    logic [LW-1:0]            w_lc;
    logic [LW-1:0]            w_rc;
    logic                     w_lc_ok;
    logic                     w_rc_ok;
    logic                     w_l_win;
    logic                     w_r_win;
    logic signed [PRI_W-1:0]  w_best_p;
    logic [ADDR_W-1:0]        w_best_idx;
    logic [ENTRY_W-1:0]       w_best_entry;
    logic                     w_full;
    logic                     w_empty;

    hpq_seq u_hpq_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    hpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_hpq_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_pos),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    assign w_a_v = w_rdata_a[VAL_W-1:0];
    assign w_a_p = w_rdata_a[ENTRY_W-1:VAL_W];
    assign w_b_v = w_rdata_b[VAL_W-1:0];
    assign w_b_p = w_rdata_b[ENTRY_W-1:VAL_W];

    assign w_parent = (r_pos - ADDR_W'(1)) >> 1;
    assign w_last   = r_count - CNT_W'(1);
    assign w_lc     = {1'b0, r_pos, 1'b1};
    assign w_rc     = {1'b0, r_pos, 1'b0} + LW'(2);
    assign w_lc_ok  = w_lc < LW'(r_count);
    assign w_rc_ok  = w_rc < LW'(r_count);

    // Left child first; the right one must beat the best so far, so ties go left
    assign w_l_win      = w_lc_ok && (w_a_p > r_cur_p);
    assign w_best_p     = w_l_win ? w_a_p : r_cur_p;
    assign w_r_win      = w_rc_ok && (w_b_p > w_best_p);
    assign w_best_idx   = w_r_win ? w_rc[ADDR_W-1:0] : w_lc[ADDR_W-1:0];
    assign w_best_entry = w_r_win ? w_rdata_b : w_rdata_a;

    assign w_full  = r_count == CNT_W'(CAPACITY);
    assign w_empty = r_count == '0;

    assign o_s_axis_tready = w_ctrl.in_ready;
    assign w_s_acc         = i_s_axis_tvalid && w_ctrl.in_ready;

    // The wait step is the only one that reads no_req and it always has tready high
    always_comb begin
        w_flags.no_req     = !i_s_axis_tvalid;
        w_flags.reject     = r_status != STAT_OK;
        w_flags.extract    = r_mode == MODE_EXTRACT;
        w_flags.pos_zero   = r_pos == '0;
        w_flags.cur_gt_par = r_cur_p > w_a_p;
        w_flags.child_win  = w_l_win || w_r_win;
        w_flags.out_busy   = r_o_valid && !i_m_axis_tready;
    end

    always_comb begin
        unique case (w_ctrl.rd_sel)
            RD_PARENT: begin
                w_raddr_a = w_parent;
                w_raddr_b = w_parent;
            end
            RD_ROOT_LAST: begin
                w_raddr_a = '0;
                w_raddr_b = w_last[ADDR_W-1:0];
            end
            RD_CHILDREN: begin
                w_raddr_a = w_lc[ADDR_W-1:0];
                w_raddr_b = w_rc[ADDR_W-1:0];
            end
            default: begin
                w_raddr_a = w_parent;
                w_raddr_b = w_parent;
            end
        endcase
    end

    always_comb begin
        w_we    = 1'b1;
        w_wdata = {r_cur_p, r_cur_v};
        unique case (w_ctrl.wr_sel)
            WR_NONE:   w_we    = 1'b0;
            WR_PARENT: w_wdata = w_rdata_a;
            WR_BEST:   w_wdata = w_best_entry;
            WR_CUR:    w_wdata = {r_cur_p, r_cur_v};
            default:   w_we    = 1'b0;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            case (w_ctrl.cnt_op)
                CNT_INC: r_count <= r_count + CNT_W'(1);
                CNT_DEC: r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
            if (w_ctrl.out_load && !w_flags.out_busy) begin
                r_o_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Request registers and sift position
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_mode  <= t_mode'(i_s_axis_tuser);
            r_cur_v <= i_s_axis_tdata[VAL_W-1:0];
            r_cur_p <= i_s_axis_tdata[VAL_W +: PRI_W];
            r_pos   <= r_count[ADDR_W-1:0];
            if (t_mode'(i_s_axis_tuser) == MODE_INSERT && w_full) begin
                r_status <= STAT_FULL;
                r_res_v  <= '0;
            end else if (t_mode'(i_s_axis_tuser) == MODE_EXTRACT && w_empty) begin
                r_status <= STAT_EMPTY;
                r_res_v  <= VALUE_NONE;
            end else begin
                r_status <= STAT_OK;
                r_res_v  <= '0;
            end
        end else begin
            case (w_ctrl.pos_sel)
                POS_ROOT:   r_pos <= '0;
                POS_PARENT: r_pos <= w_parent;
                POS_BEST:   r_pos <= w_best_idx;
                default:    r_pos <= r_pos;
            endcase
            // take the root's value out and lift the last entry into the hole
            if (w_ctrl.load_ext) begin
                r_res_v <= w_a_v;
                r_cur_v <= w_b_v;
                r_cur_p <= w_b_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load && !w_flags.out_busy) begin
            r_o_value  <= r_res_v;
            r_o_status <= r_status;
            r_o_count  <= r_count;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = M_DW'({r_o_count, r_o_value});
    assign o_m_axis_tuser  = r_o_status;

endmodule

[rtl/hpq_checker.sv]
// Port-level checks of the heap priority queue core, attached by the bind below.
// Depends on hpq_pkg for the status codes and field widths.
module hpq_checker import hpq_pkg::*; #(
    parameter  int CAPACITY = HPQ_CAPACITY,
    localparam int CNT_W    = $clog2(CAPACITY + 1),
    localparam int M_DW     = ((VAL_W + CNT_W + 7) / 8) * 8
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              i_s_tready,
    input logic              i_m_tvalid,
    input logic              i_m_tready,
    input logic [M_DW-1:0]   i_m_tdata,
    input logic [STAT_W-1:0] i_m_tuser
);

    logic [VAL_W-1:0] w_value;
    logic [CNT_W-1:0] w_occ;

    assign w_value = i_m_tdata[VAL_W-1:0];
    assign w_occ   = i_m_tdata[VAL_W +: CNT_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed while stalled");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> w_occ <= CNT_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser == STAT_FULL |-> w_occ == CNT_W'(CAPACITY) && w_value == '0)
        else $error("dropped insert without a full queue");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser == STAT_EMPTY |-> w_occ == '0 && w_value == VALUE_NONE)
        else $error("empty extract with wrong result");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("request taken while the previous one is in work");

endmodule

bind binary_heap_priority_queue_core hpq_checker #(
    .CAPACITY (CAPACITY)
) u_hpq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata),
    .i_m_tuser  (o_m_axis_tuser)
);

[verif/tb.sv]
// Testbench of binary_heap_priority_queue_core: a directed table, then random requests,
// each checked against its table outcome or a heap predictor fed the accepted requests.
// Depends on rtl/hpq_pkg.sv and rtl/binary_heap_priority_queue_core.sv.
`timescale 1ns / 100ps

module tb import hpq_pkg::*; ();

    localparam int QUEUE_DEPTH   = HPQ_CAPACITY;
    localparam int OCC_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int RESP_W        = ((VAL_W + OCC_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int CALM_TAIL     = 300;
    localparam int HOLD_CYCLES   = 300;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int SCRIPT_ROWS   = 23;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        t_status                 status;
        logic [OCC_W-1:0]        occ;
    } t_heap_result;

    typedef struct packed {
        t_mode                   mode;
        logic signed [VAL_W-1:0] value;
        logic signed [PRI_W-1:0] prio;
        logic                    typed;
        t_heap_result            outcome;
    } t_script_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [S_DW-1:0]   s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tready = 1'b0;
    logic              o_s_axis_tready;
    logic              o_m_axis_tvalid;
    logic [RESP_W-1:0] o_m_axis_tdata;
    logic [STAT_W-1:0] o_m_axis_tuser;

    // Predictor copy of the heap
    logic signed [VAL_W-1:0] heap_val [QUEUE_DEPTH];
    logic signed [PRI_W-1:0] heap_pri [QUEUE_DEPTH];
    int                      heap_size = 0;

    t_heap_result pending_results[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           result_count = 0;
    bit           tx_idle_on = 1'b0;
    bit           rx_idle_on = 1'b0;
    bit           hold_request = 1'b0;

    t_script_row script [SCRIPT_ROWS] = '{
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b1, '{VALUE_NONE, STAT_EMPTY, 7'd0}},
        '{MODE_INSERT, 32'h7FFF_FFFF, 32'sd0, 1'b1, '{32'sd0, STAT_OK, 7'd1}},
        '{MODE_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{32'sd0, STAT_OK, 7'd2}},
        '{MODE_INSERT, 32'sd5, 32'h8000_0000, 1'b1, '{32'sd0, STAT_OK, 7'd3}},
        '{MODE_INSERT, 32'sd6, 32'sd0, 1'b1, '{32'sd0, STAT_OK, 7'd4}},
        '{MODE_INSERT, 32'sd7, 32'sd0, 1'b1, '{32'sd0, STAT_OK, 7'd5}},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b1, '{32'h8000_0000, STAT_OK, 7'd4}},
        // three equal keys at zero: order set by the sift rules
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b0, '0},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b0, '0},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b0, '0},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b1, '{32'sd5, STAT_OK, 7'd0}},
        '{MODE_EXTRACT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{VALUE_NONE, STAT_EMPTY, 7'd0}},
        '{MODE_INSERT, 32'sd1, -32'sd1, 1'b1, '{32'sd0, STAT_OK, 7'd1}},
        '{MODE_INSERT, 32'sd2, -32'sd1, 1'b0, '0},
        '{MODE_INSERT, 32'sd3, -32'sd1, 1'b0, '0},
        '{MODE_INSERT, 32'sd4, -32'sd1, 1'b0, '0},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b0, '0},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b0, '0},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b0, '0},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b0, '0},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b1, '{VALUE_NONE, STAT_EMPTY, 7'd0}},
        // a stored value of all ones must not read as the empty marker
        '{MODE_INSERT, -32'sd1, -32'sd1, 1'b1, '{32'sd0, STAT_OK, 7'd1}},
        '{MODE_EXTRACT, 32'sd0, 32'sd0, 1'b1, '{-32'sd1, STAT_OK, 7'd0}}
    };

    binary_heap_priority_queue_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    function automatic void swap_slots(int a, int b);
        logic signed [VAL_W-1:0] v;
        logic signed [PRI_W-1:0] p;
        v = heap_val[a];
        p = heap_pri[a];
        heap_val[a] = heap_val[b];
        heap_pri[a] = heap_pri[b];
        heap_val[b] = v;
        heap_pri[b] = p;
    endfunction

    function automatic t_heap_result predict_request(t_mode mode, logic signed [VAL_W-1:0] val,
                                                     logic signed [PRI_W-1:0] pri);
        t_heap_result r;
        int pos;
        int parent;
        int lc;
        int rc;
        int best;
        r.value  = '0;
        r.status = STAT_OK;
        if (mode == MODE_INSERT) begin
            if (heap_size >= QUEUE_DEPTH) begin
                r.status = STAT_FULL;
            end else begin
                heap_val[heap_size] = val;
                heap_pri[heap_size] = pri;
                pos = heap_size;
                heap_size++;
                // climb while strictly above the parent
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (!(heap_pri[pos] > heap_pri[parent])) break;
                    swap_slots(pos, parent);
                    pos = parent;
                end
            end
        end else if (heap_size == 0) begin
            r.value  = VALUE_NONE;
            r.status = STAT_EMPTY;
        end else begin
            r.value = heap_val[0];
            heap_size--;
            heap_val[0] = heap_val[heap_size];
            heap_pri[0] = heap_pri[heap_size];
            pos = 0;
            // descend; a tie between the children goes left
            forever begin
                lc   = 2 * pos + 1;
                rc   = 2 * pos + 2;
                best = pos;
                if (lc < heap_size && heap_pri[lc] > heap_pri[best]) best = lc;
                if (rc < heap_size && heap_pri[rc] > heap_pri[best]) best = rc;
                if (best == pos) break;
                swap_slots(pos, best);
                pos = best;
            end
        end
        r.occ = heap_size[OCC_W-1:0];
        return r;
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    // Offer one request, hold it until taken, then record what it must produce
    task automatic send_request(t_mode mode, logic signed [VAL_W-1:0] val,
                                logic signed [PRI_W-1:0] pri, logic typed,
                                t_heap_result outcome);
        t_heap_result predicted;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pri, val};
        s_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = predict_request(mode, val, pri);
        pending_results = {pending_results, (typed ? outcome : predicted)};
    endtask

    function automatic logic signed [PRI_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 7)) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_heap_result exp_res;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result %0d arrived with nothing outstanding",
                                       result_count));
            end else begin
                exp_res = pending_results.pop_front();
                if ($signed(o_m_axis_tdata[VAL_W-1:0]) !== exp_res.value)
                    note_failure($sformatf("result %0d value: exp %0d got %0d", result_count,
                                           exp_res.value, $signed(o_m_axis_tdata[VAL_W-1:0])));
                if (o_m_axis_tuser !== exp_res.status)
                    note_failure($sformatf("result %0d status: exp %0d got %0d", result_count,
                                           exp_res.status, o_m_axis_tuser));
                if (o_m_axis_tdata[VAL_W +: OCC_W] !== exp_res.occ)
                    note_failure($sformatf("result %0d occupancy: exp %0d got %0d",
                                           result_count, exp_res.occ,
                                           o_m_axis_tdata[VAL_W +: OCC_W]));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    initial begin
        t_mode mode;
        int    sent;
        int    phase;
        int    phase_len;
        int    ins_pct;
        int    wait_cycles;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        foreach (script[i])
            send_request(script[i].mode, script[i].value, script[i].prio,
                         script[i].typed, script[i].outcome);

        // Random phases; the first fills past capacity, the second drains past empty
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: ins_pct = 100;
                1: ins_pct = 0;
                default: begin
                    case ($urandom_range(0, 3))
                        0: ins_pct = 10;
                        1: ins_pct = 50;
                        2: ins_pct = 85;
                        default: ins_pct = 100;
                    endcase
                end
            endcase
            phase_len = (phase < 2) ? QUEUE_DEPTH + 10 : $urandom_range(40, 160);
            if (phase == 2) hold_request = 1'b1;
            if (sent >= RANDOM_ITEMS - CALM_TAIL) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_EXTRACT;
                send_request(mode, $urandom, pick_priority(), 1'b0, '0);
                sent++;
                if (sent == RANDOM_ITEMS - CALM_TAIL) begin
                    tx_idle_on = 1'b0;
                    rx_idle_on = 1'b0;
                end
            end
            phase++;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        wait_cycles = DRAIN_CYCLES;
        repeat (wait_cycles) @(posedge i_clk);

        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
rtl/hpq_pkg.sv
rtl/hpq_ram.sv
rtl/hpq_seq.sv
rtl/binary_heap_priority_queue_core.sv
rtl/hpq_checker.sv
verif/tb.sv
